### hw/rtl/fsk_tx_pkg.sv
package fsk_tx_pkg;

  // Message buffer depth default
  localparam int unsigned BufferBytes = 64;

  // Field widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned IndexW   = 6;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned LenW     = 7;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  // Register reset values
  localparam logic [CfgW-1:0] HighPeriodRst  = 16'd86;
  localparam logic [CfgW-1:0] HighCompareRst = 16'd43;
  localparam logic [CfgW-1:0] LowPeriodRst   = 16'd97;
  localparam logic [CfgW-1:0] LowCompareRst  = 16'd48;
  localparam logic [CfgW-1:0] BaudReloadRst  = 16'd10;
  localparam logic [LenW-1:0] MsgLengthRst   = 7'd64;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_HIGH_PERIOD  = 3'd0,
    REG_HIGH_COMPARE = 3'd1,
    REG_LOW_PERIOD   = 3'd2,
    REG_LOW_COMPARE  = 3'd3,
    REG_BAUD_RELOAD  = 3'd4,
    REG_MSG_LENGTH   = 3'd5
  } reg_e;

endpackage

### hw/rtl/fsk_tx_if.sv
interface fsk_tx_req_if
  import fsk_tx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FuncW-1:0]  func;
  logic [IndexW-1:0] byte_index;
  logic [ByteW-1:0]  byte_value;

  modport source (output valid, func, byte_index, byte_value, input ready);
  modport sink (input valid, func, byte_index, byte_value, output ready);
  modport monitor (input valid, ready, func, byte_index, byte_value);
endinterface

interface fsk_tx_res_if
  import fsk_tx_pkg::*;
();
  logic valid;
  logic ready;
  logic carrier_level;
  logic busy_res;
  logic done_res;

  modport source (output valid, carrier_level, busy_res, done_res, input ready);
  modport sink (input valid, carrier_level, busy_res, done_res, output ready);
  modport monitor (input valid, ready, carrier_level, busy_res, done_res);
endinterface

### hw/rtl/fsk_pwm_bit_transmitter_unit.sv
// Binary FSK transmitter with a PWM carrier. Requests on req_i are: load a
// message byte (func 0), start a transmission (func 1) and one carrier clock
// tick (func 2); func 3 is ignored. Every request yields exactly one result on
// res_o, in the cycle after acceptance. One request is taken per clock as long as
// the result side keeps up: the result register is the only stage, and
// req_i.ready drops only while a result is held and res_o.ready is low.
// Bits go out MSB first from byte 0; a one bit runs the carrier at
// high_period/high_compare, a zero bit at low_period/low_compare, and each bit
// lasts baud_reload+1 carrier periods. The carrier is high while the count is
// at or below the compare value. The tick that ends the last bit raises
// done_res; busy_res on a tick shows the state before the tick. The message
// buffer is a plain RAM with no reset and no clearing pass: only bytes that
// were loaded may be sent. The next byte is prefetched from the RAM every
// cycle, and byte 0 is mirrored in flops so a start can use it at once.
// Registers (APB, 32-bit, byte address 4*i): 0 high_period, 1 high_compare,
// 2 low_period, 3 low_compare, 4 baud_reload, 5 message_length (0 acts as 1,
// values above the buffer depth saturate to the depth).
module fsk_pwm_bit_transmitter_unit
  import fsk_tx_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BufferBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [PdataW-1:0]   pwdata,
  output logic [PdataW-1:0]   prdata,
  output logic                pready,
  // request / result channels
  fsk_tx_req_if.sink          req_i,
  fsk_tx_res_if.source        res_o
);

  localparam int unsigned AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned PW = $clog2(BUFFER_BYTES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0] high_period_q, high_compare_q, low_period_q, low_compare_q;
  logic [CfgW-1:0] baud_reload_q;
  logic [LenW-1:0] msg_length_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_period_q  <= HighPeriodRst;
      high_compare_q <= HighCompareRst;
      low_period_q   <= LowPeriodRst;
      low_compare_q  <= LowCompareRst;
      baud_reload_q  <= BaudReloadRst;
      msg_length_q   <= MsgLengthRst;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_HIGH_PERIOD:  high_period_q  <= pwdata[CfgW-1:0];
        REG_HIGH_COMPARE: high_compare_q <= pwdata[CfgW-1:0];
        REG_LOW_PERIOD:   low_period_q   <= pwdata[CfgW-1:0];
        REG_LOW_COMPARE:  low_compare_q  <= pwdata[CfgW-1:0];
        REG_BAUD_RELOAD:  baud_reload_q  <= pwdata[CfgW-1:0];
        REG_MSG_LENGTH:   msg_length_q   <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_HIGH_PERIOD:  prdata = PdataW'(high_period_q);
      REG_HIGH_COMPARE: prdata = PdataW'(high_compare_q);
      REG_LOW_PERIOD:   prdata = PdataW'(low_period_q);
      REG_LOW_COMPARE:  prdata = PdataW'(low_compare_q);
      REG_BAUD_RELOAD:  prdata = PdataW'(baud_reload_q);
      REG_MSG_LENGTH:   prdata = PdataW'(msg_length_q);
      default:          prdata = '0;
    endcase
  end

  // Effective length: 0 acts as 1, saturate at the buffer depth
  logic [PW-1:0] len_eff;
  always_comb begin
    if (msg_length_q == '0) begin
      len_eff = PW'(1);
    end else if (32'(msg_length_q) > BUFFER_BYTES) begin
      len_eff = PW'(BUFFER_BYTES);
    end else begin
      len_eff = PW'(msg_length_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic res_valid_q;
  logic req_fire;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Message RAM, byte 0 mirror and next-byte prefetch
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] msg_mem [BUFFER_BYTES];
  logic [ByteW-1:0] next_byte_q;
  logic [ByteW-1:0] byte0_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [PW-1:0]    byte_pos_d, byte_pos_q;

  assign wr_en   = req_fire && (req_i.func == FUNC_LOAD) &&
                   (32'(req_i.byte_index) < BUFFER_BYTES);
  assign wr_addr = AW'(req_i.byte_index);
  // Prefetch the byte after the one in flight; unused past the end
  assign rd_addr = AW'(byte_pos_d + PW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      msg_mem[wr_addr] <= req_i.byte_value;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      next_byte_q <= req_i.byte_value;
    end else begin
      next_byte_q <= msg_mem[rd_addr];
    end
    if (wr_en && (wr_addr == '0)) begin
      byte0_q <= req_i.byte_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Transmit state
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] cur_byte_d, cur_byte_q;
  logic [2:0]       bit_pos_d, bit_pos_q;
  logic [CfgW-1:0]  periods_left_d, periods_left_q;
  logic [CfgW-1:0]  carrier_cnt_d, carrier_cnt_q;
  logic             cur_bit_d, cur_bit_q;
  logic             sending_d, sending_q;
  logic             level_d, busy_d, done_d;
  logic [CfgW-1:0]  per, cmp;
  logic [PW-1:0]    next_pos;

  assign per      = cur_bit_q ? high_period_q  : low_period_q;
  assign cmp      = cur_bit_q ? high_compare_q : low_compare_q;
  assign next_pos = byte_pos_q + PW'(1);

  always_comb begin
    byte_pos_d     = byte_pos_q;
    bit_pos_d      = bit_pos_q;
    periods_left_d = periods_left_q;
    carrier_cnt_d  = carrier_cnt_q;
    cur_bit_d      = cur_bit_q;
    cur_byte_d     = cur_byte_q;
    sending_d      = sending_q;
    level_d        = 1'b0;
    busy_d         = sending_q;
    done_d         = 1'b0;

    if (req_fire) begin
      unique case (req_i.func)
        FUNC_LOAD: begin
          // keep the byte in flight coherent with the RAM
          if (wr_en && (32'(req_i.byte_index) == 32'(byte_pos_q))) begin
            cur_byte_d = req_i.byte_value;
          end
        end
        FUNC_START: begin
          byte_pos_d     = '0;
          bit_pos_d      = '0;
          carrier_cnt_d  = '0;
          periods_left_d = baud_reload_q;
          cur_byte_d     = byte0_q;
          cur_bit_d      = byte0_q[7];
          sending_d      = 1'b1;
          busy_d         = 1'b1;
        end
        FUNC_TICK: begin
          if (sending_q) begin
            level_d = (carrier_cnt_q <= cmp);
            if (carrier_cnt_q >= per) begin
              carrier_cnt_d = '0;
              if (periods_left_q == '0) begin
                bit_pos_d = bit_pos_q + 3'd1;
                if (bit_pos_q == 3'd7) begin
                  byte_pos_d = next_pos;
                  if (next_pos >= len_eff) begin
                    sending_d = 1'b0;
                    done_d    = 1'b1;
                  end else begin
                    cur_byte_d     = next_byte_q;
                    cur_bit_d      = next_byte_q[7];
                    periods_left_d = baud_reload_q;
                  end
                end else begin
                  // MSB first: bit n of the byte sits at index 7-n
                  cur_bit_d      = cur_byte_q[~bit_pos_d];
                  periods_left_d = baud_reload_q;
                end
              end else begin
                periods_left_d = periods_left_q - CfgW'(1);
              end
            end else begin
              carrier_cnt_d = carrier_cnt_q + CfgW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q     <= '0;
      bit_pos_q      <= '0;
      periods_left_q <= '0;
      carrier_cnt_q  <= '0;
      cur_bit_q      <= 1'b0;
      sending_q      <= 1'b0;
    end else begin
      byte_pos_q     <= byte_pos_d;
      bit_pos_q      <= bit_pos_d;
      periods_left_q <= periods_left_d;
      carrier_cnt_q  <= carrier_cnt_d;
      cur_bit_q      <= cur_bit_d;
      sending_q      <= sending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_byte_q <= cur_byte_d;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic level_q, busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      level_q <= level_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.carrier_level = level_q;
  assign res_o.busy_res      = busy_q;
  assign res_o.done_res      = done_q;

endmodule

### hw/rtl/fsk_tx_checker.sv
module fsk_tx_checker
  import fsk_tx_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  fsk_tx_req_if.sink   req_i,
  fsk_tx_res_if.source res_o
);

  // Carrier only toggles during a transmission
  a_level_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.carrier_level || res_o.busy_res))
    else $error("carrier high while not busy");

  // The ending tick still reports busy
  a_done_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.done_res || res_o.busy_res))
    else $error("done without busy");

  // A start request answers busy in the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.func == FUNC_START))
    |=> (res_o.valid && res_o.busy_res && !res_o.done_res && !res_o.carrier_level))
    else $error("start did not report busy");

  // Result holds while stalled
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready)
    |=> (res_o.valid && $stable(res_o.carrier_level) && $stable(res_o.busy_res)
         && $stable(res_o.done_res)))
    else $error("result changed while stalled");

endmodule

bind fsk_pwm_bit_transmitter_unit fsk_tx_checker u_fsk_tx_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .req_i (req_i),
  .res_o (res_o)
);
